// ===== rtl/pdpc_pkg.sv =====
package pdpc_pkg;

    // Field widths
    localparam int DUTY_W  = 31;
    localparam int PER_W   = 31;
    localparam int CLK_W   = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 12;
    localparam int SHIFT_W = 4;
    localparam int CW_W    = 32;

    // Internal arithmetic widths
    localparam int Q_W     = 22;             // period / 1000 < 2^22
    localparam int TOT_W   = 30;             // (period / 1000) * clock_mhz < 2^30
    localparam int PROD_W  = PER_W + 32;     // period * reciprocal
    localparam int DVD_W   = PER_W + TOT_W;  // total * duty
    localparam int LEN_W   = $clog2(TOT_W + 1);

    // Divide by 1000 as multiply by ceil(2^41 / 1000), then shift by 41
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;
    localparam int          RECIP_SHIFT = 41;

    // Defaults and limits
    localparam logic [CLK_W-1:0] CLOCK_MHZ_RESET = 8'd96;
    localparam int COUNT_BITS_DEF = 12;
    localparam int MAX_SHIFT      = 15;
    localparam int HIGH_POS       = 20;
    localparam int LOW_POS        = 8;
    localparam int SHIFT_POS      = 4;

    // Request queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // Classified request, as held in the queue
    typedef struct packed {
        logic              inv;
        logic [DUTY_W-1:0] duty;
        logic [PER_W-1:0]  period;
    } req_t;

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One slot of the restoring divider
    typedef struct packed {
        logic             inv;
        logic [PER_W-1:0] period;
        logic [TOT_W-1:0] tot;
        logic [PER_W-1:0] rem;
        logic [TOT_W-1:0] low;
    } div_t;

    // Bit length of a count (position of the top set bit, plus one)
    function automatic logic [LEN_W-1:0] bit_len(input logic [TOT_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < TOT_W; i++) begin
            if (v[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/pdpc_front.sv =====
module pdpc_front
    import pdpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DUTY_W-1:0] duty_time_ns,
    input  logic [PER_W-1:0]  period_time_ns,
    input  q_stat_t           q_stat,
    output logic              push,
    output req_t              push_req
);

    logic front_valid_reg;
    logic front_valid_next;
    req_t req_reg;
    logic accept;

    // Hold off the source only while the staged request cannot move on
    assign in_stall = front_valid_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = front_valid_reg && !q_stat.full;
    assign push_req = req_reg;

    assign front_valid_next = accept || (front_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Capture and classify: zero period or duty above period is rejected
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.duty   <= duty_time_ns;
            req_reg.period <= period_time_ns;
            req_reg.inv    <= (period_time_ns == '0) || (duty_time_ns > period_time_ns);
        end
    end

endmodule

// ===== rtl/pdpc_queue.sv =====
module pdpc_queue
    import pdpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  req_t    push_req,
    input  logic    pop,
    output req_t    pop_req,
    output q_stat_t q_stat
);

    req_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_req      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/pdpc_div_step.sv =====
module pdpc_div_step
    import pdpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic step_in_valid,
    input  div_t step_in,
    output logic step_out_valid,
    output div_t step_out
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [PER_W:0]   trial;
    logic             ge;

    assign step_out_valid = valid_reg;
    assign step_out       = data_reg;

    // One restoring step: bring down a dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {step_in.rem, step_in.low[TOT_W-1]};
        ge        = (trial >= {1'b0, step_in.period});
        data_next = step_in;
        if (ge)
        begin
            data_next.rem = PER_W'(trial - {1'b0, step_in.period});
        end
        else
        begin
            data_next.rem = trial[PER_W-1:0];
        end
        data_next.low = {step_in.low[TOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= step_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/pdpc_back.sv =====
module pdpc_back
    import pdpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CLK_W-1:0]   clock_mhz,
    input  q_stat_t            q_stat,
    input  req_t               pop_req,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [CNT_W-1:0]   high_count,
    output logic [CNT_W-1:0]   low_count,
    output logic [SHIFT_W-1:0] prescale_shift,
    output logic [CW_W-1:0]    control_word
);

    logic advance;

    // Stage 1: period times reciprocal of 1000
    logic              s1_valid_reg;
    logic              s1_inv_reg;
    logic [DUTY_W-1:0] s1_duty_reg;
    logic [PER_W-1:0]  s1_period_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    // Stage 2: total ticks
    logic              s2_valid_reg;
    logic              s2_inv_reg;
    logic [DUTY_W-1:0] s2_duty_reg;
    logic [PER_W-1:0]  s2_period_reg;
    logic [TOT_W-1:0]  s2_tot_reg;
    logic [Q_W-1:0]    s2_q;

    // Stage 3: dividend total * duty
    logic              s3_valid_reg;
    logic              s3_inv_reg;
    logic [PER_W-1:0]  s3_period_reg;
    logic [TOT_W-1:0]  s3_tot_reg;
    logic [DVD_W-1:0]  s3_dvd_reg;

    // Divider chain
    logic              dv_valid [TOT_W+1];
    div_t              dv_data  [TOT_W+1];

    // Stage A: high and low counts
    logic              sa_valid_reg;
    logic              sa_inv_reg;
    logic [TOT_W-1:0]  sa_hi_reg;
    logic [TOT_W-1:0]  sa_lo_reg;

    // Stage B: bit length of the larger count
    logic              sb_valid_reg;
    logic              sb_inv_reg;
    logic [TOT_W-1:0]  sb_hi_reg;
    logic [TOT_W-1:0]  sb_lo_reg;
    logic [LEN_W-1:0]  sb_len_reg;

    // Output register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [CNT_W-1:0]   high_reg;
    logic [CNT_W-1:0]   low_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [CW_W-1:0]    cw_reg;

    // Final stage combinational values
    logic [LEN_W-1:0]      sh_full;
    logic                  ovf;
    logic [TOT_W-1:0]      hi_sh;
    logic [TOT_W-1:0]      lo_sh;
    logic [COUNT_BITS-1:0] hi_cb;
    logic [COUNT_BITS-1:0] lo_cb;
    logic [SHIFT_W-1:0]    sh_4;

    // Whole pipeline moves unless a finished result is held
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_stat.empty;

    assign s2_q = s1_prod_reg[PROD_W-1:RECIP_SHIFT];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            sa_valid_reg  <= 1'b0;
            sb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_stat.empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            sa_valid_reg  <= dv_valid[TOT_W];
            sb_valid_reg  <= sa_valid_reg;
            out_valid_reg <= sb_valid_reg;
        end
    end

    // Front arithmetic stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_inv_reg    <= pop_req.inv;
            s1_duty_reg   <= pop_req.duty;
            s1_period_reg <= pop_req.period;
            s1_prod_reg   <= PROD_W'(pop_req.period) * PROD_W'(RECIP_1000);

            s2_inv_reg    <= s1_inv_reg;
            s2_duty_reg   <= s1_duty_reg;
            s2_period_reg <= s1_period_reg;
            s2_tot_reg    <= TOT_W'(s2_q) * TOT_W'(clock_mhz);

            s3_inv_reg    <= s2_inv_reg;
            s3_period_reg <= s2_period_reg;
            s3_tot_reg    <= s2_tot_reg;
            s3_dvd_reg    <= DVD_W'(s2_tot_reg) * DVD_W'(s2_duty_reg);
        end
    end

    // Quotient stays below 2^TOT_W, so the top dividend bits start below the divisor
    assign dv_valid[0]       = s3_valid_reg;
    assign dv_data[0].inv    = s3_inv_reg;
    assign dv_data[0].period = s3_period_reg;
    assign dv_data[0].tot    = s3_tot_reg;
    assign dv_data[0].rem    = s3_dvd_reg[DVD_W-1:TOT_W];
    assign dv_data[0].low    = s3_dvd_reg[TOT_W-1:0];

    for (genvar g = 0; g < TOT_W; g++)
    begin : g_div
        pdpc_div_step u_step (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (advance),
            .step_in_valid  (dv_valid[g]),
            .step_in        (dv_data[g]),
            .step_out_valid (dv_valid[g+1]),
            .step_out       (dv_data[g+1])
        );
    end

    // Counts and bit length
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sa_inv_reg <= dv_data[TOT_W].inv;
            sa_hi_reg  <= dv_data[TOT_W].low;
            sa_lo_reg  <= dv_data[TOT_W].tot - dv_data[TOT_W].low;

            sb_inv_reg <= sa_inv_reg;
            sb_hi_reg  <= sa_hi_reg;
            sb_lo_reg  <= sa_lo_reg;
            sb_len_reg <= bit_len(sa_hi_reg | sa_lo_reg);
        end
    end

    // Prescale shift and packing
    always_comb
    begin
        sh_full = '0;
        if (sb_len_reg > LEN_W'(COUNT_BITS))
        begin
            sh_full = sb_len_reg - LEN_W'(COUNT_BITS);
        end
        ovf   = (sh_full > LEN_W'(MAX_SHIFT));
        sh_4  = SHIFT_W'(sh_full);
        hi_sh = sb_hi_reg >> sh_full;
        lo_sh = sb_lo_reg >> sh_full;
        hi_cb = hi_sh[COUNT_BITS-1:0];
        lo_cb = lo_sh[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (sb_inv_reg)
            begin
                status_reg <= ST_INVALID;
                high_reg   <= '0;
                low_reg    <= '0;
                shift_reg  <= '0;
                cw_reg     <= '0;
            end
            else if (ovf)
            begin
                status_reg <= ST_OVERFLOW;
                high_reg   <= '0;
                low_reg    <= '0;
                shift_reg  <= '0;
                cw_reg     <= '0;
            end
            else
            begin
                status_reg <= ST_OK;
                high_reg   <= CNT_W'(hi_cb);
                low_reg    <= CNT_W'(lo_cb);
                shift_reg  <= sh_4;
                cw_reg     <= (CW_W'(hi_cb) << HIGH_POS) | (CW_W'(lo_cb) << LOW_POS)
                              | (CW_W'(sh_4) << SHIFT_POS);
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign high_count     = high_reg;
    assign low_count      = low_reg;
    assign prescale_shift = shift_reg;
    assign control_word   = cw_reg;

endmodule

// ===== rtl/pwm_duty_period_to_counts.sv =====
// Throughput: one request per cycle while out_stall is low; the 30-step pipelined restoring
// divider and the multiplier stages all advance together, one request in each stage.
// A 4-entry request queue sits between the input stage and the arithmetic pipeline.
// Reset (rst_n low, asynchronous) empties the queue and pipeline and sets clock_mhz to 96.
module pwm_duty_period_to_counts
    import pdpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CLK_W-1:0]   cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [DUTY_W-1:0]  duty_time_ns,
    input  logic [PER_W-1:0]   period_time_ns,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [CNT_W-1:0]   high_count,
    output logic [CNT_W-1:0]   low_count,
    output logic [SHIFT_W-1:0] prescale_shift,
    output logic [CW_W-1:0]    control_word
);

    logic [CLK_W-1:0] clock_mhz_reg;
    q_stat_t          q_stat;
    logic             push;
    req_t             push_req;
    logic             pop;
    req_t             pop_req;

    // Clock frequency register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_mhz_reg <= CLOCK_MHZ_RESET;
        end
        else if (cfg_write_en)
        begin
            clock_mhz_reg <= cfg_write_data;
        end
    end

    pdpc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .duty_time_ns   (duty_time_ns),
        .period_time_ns (period_time_ns),
        .q_stat         (q_stat),
        .push           (push),
        .push_req       (push_req)
    );

    pdpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .pop_req  (pop_req),
        .q_stat   (q_stat)
    );

    pdpc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .clock_mhz      (clock_mhz_reg),
        .q_stat         (q_stat),
        .pop_req        (pop_req),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .high_count     (high_count),
        .low_count      (low_count),
        .prescale_shift (prescale_shift),
        .control_word   (control_word)
    );

endmodule

// ===== rtl/pdpc_checker.sv =====
module pdpc_checker
    import pdpc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [STAT_W-1:0]  status,
    input logic [CNT_W-1:0]   high_count,
    input logic [CNT_W-1:0]   low_count,
    input logic [SHIFT_W-1:0] prescale_shift,
    input logic [CW_W-1:0]    control_word
);

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its control word and status
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(control_word) && $stable(status))
        else $error("result changed while stalled");

    // Rejected or overflowed requests carry all-zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (high_count == '0) && (low_count == '0) && (prescale_shift == '0)
            && (control_word == '0))
        else $error("nonzero fields on error result");

    // Control word packs the low count and shift as reported
    a_cw_pack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |->
            (control_word[19:4] == {low_count, prescale_shift})
            && (control_word[3:0] == 4'd0))
        else $error("control word does not match fields");

    // Status stays within its defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_INVALID)
                      || (status == ST_OVERFLOW))
        else $error("undefined status code");

endmodule

bind pwm_duty_period_to_counts pdpc_checker u_pdpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .high_count     (high_count),
    .low_count      (low_count),
    .prescale_shift (prescale_shift),
    .control_word   (control_word)
);
